/* src/wis_pkg.sv */
package wis_pkg;

	localparam int unsigned ENTRIES_DEF = 64;

	localparam int unsigned WEIGHT_W  = 32;
	localparam int unsigned FRAC_W    = 33;
	localparam int unsigned TOTAL_W   = 38;
	localparam int unsigned PROD_W    = FRAC_W + TOTAL_W;
	localparam int unsigned RHS_HI_W  = PROD_W - WEIGHT_W;
	localparam int unsigned PROB_W    = 16;
	localparam int unsigned INDEX_W   = 6;
	localparam int unsigned COUNT_W   = 7;
	localparam int unsigned STEP_W    = $clog2(FRAC_W);

	localparam int unsigned S_TDATA_W = ((WEIGHT_W + FRAC_W + 7) / 8) * 8;
	localparam int unsigned M_TDATA_W = ((INDEX_W + PROB_W + COUNT_W + 7) / 8) * 8;
	localparam int unsigned M_TUSER_W = 2;

	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef struct packed {
		logic [PROD_W-1:0]   a;
		logic [PROD_W-1:0]   b;
		logic                sub;
		logic [RHS_HI_W-1:0] lim;
	} alu_req_t;

	typedef struct packed {
		logic [PROD_W-1:0] res;
		logic              cout;
		logic              gt;
	} alu_rsp_t;

endpackage

/* src/wis_ram.sv */
module wis_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/wis_alu.sv */
module wis_alu (
	input  wis_pkg::alu_req_t req,
	output wis_pkg::alu_rsp_t rsp
);

	logic [wis_pkg::PROD_W-1:0] b_eff;
	logic [wis_pkg::PROD_W:0]   full;

	// add, or subtract with cout = no borrow
	assign b_eff = req.sub ? ~req.b : req.b;
	assign full  = {1'b0, req.a} + {1'b0, b_eff} + (wis_pkg::PROD_W + 1)'(req.sub);

	always_comb begin
		rsp      = '0;
		rsp.res  = full[wis_pkg::PROD_W-1:0];
		rsp.cout = full[wis_pkg::PROD_W];
		// running sum (mod total width) against fraction * total with its low 32 bits dropped
		rsp.gt   = {1'b0, full[wis_pkg::TOTAL_W-1:0]} > req.lim;
	end

endmodule

/* src/weighted_index_sampler_core.sv */
// channel  dir  tdata                                   tuser
// s_*      in   [31:0] weight, [64:32] random_fraction  kind
// m_*      out  [5:0] chosen_index, [21:6] probability,  [0] found, [1] table_full
//               [28:22] entry_count
//
// Append: accept, then result. Sample for n stored weights runs on the shared adder:
// 33 shift-add steps for fraction * total, one RAM read and add per weight walked,
// one saturation check and 16 restoring division steps
// (the division is skipped when the probability saturates or the total is zero).
// Reset clears count, total, the output valid and the sequencer; table contents stay undefined.
// s_tready is high only while idle; a finished result waits for m_tready.
module weighted_index_sampler_core #(
	parameter int unsigned ENTRIES = wis_pkg::ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wis_pkg::S_TDATA_W-1:0]   s_tdata,  // weight, random_fraction
	input  logic                            s_tuser,  // kind
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wis_pkg::M_TDATA_W-1:0]   m_tdata,  // chosen_index, probability, entry_count
	output logic [wis_pkg::M_TUSER_W-1:0]   m_tuser   // found, table_full
);

	localparam int unsigned AW     = $clog2(ENTRIES);
	localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
	localparam int unsigned CNT_XW = (CNT_W > wis_pkg::COUNT_W) ? CNT_W : wis_pkg::COUNT_W;
	localparam int unsigned IDX_XW = (AW > wis_pkg::INDEX_W) ? AW : wis_pkg::INDEX_W;

	localparam int unsigned TW = wis_pkg::TOTAL_W;
	localparam int unsigned PW = wis_pkg::PROB_W;
	localparam int unsigned SW = wis_pkg::STEP_W;

	localparam int unsigned ST_W    = 3;
	localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
	localparam logic [ST_W-1:0] ST_MUL  = 3'd1;
	localparam logic [ST_W-1:0] ST_WALK = 3'd2;
	localparam logic [ST_W-1:0] ST_SAT  = 3'd3;
	localparam logic [ST_W-1:0] ST_DIV  = 3'd4;
	localparam logic [ST_W-1:0] ST_FIN  = 3'd5;

	localparam logic [SW-1:0] MUL_LAST = SW'(wis_pkg::FRAC_W - 1);
	localparam logic [SW-1:0] DIV_LAST = SW'(PW - 1);

	logic [ST_W-1:0]               state_q;
	logic [CNT_W-1:0]              count_q;
	logic [TW-1:0]                 total_q;
	logic                          m_tvalid_q;

	logic [wis_pkg::PROD_W-1:0]    acc_q;
	logic [wis_pkg::FRAC_W-1:0]    frac_q;
	logic [TW-1:0]                 sum_q;
	logic [TW-1:0]                 rem_q;
	logic [PW-1:0]                 quo_q;
	logic [SW-1:0]                 step_q;
	logic [CNT_W-1:0]              proc_q;
	logic [AW-1:0]                 pick_q;
	logic [wis_pkg::WEIGHT_W-1:0]  w_q;
	logic                          found_q;
	logic                          full_q;

	logic                          out_found_q;
	logic                          out_full_q;
	logic [wis_pkg::INDEX_W-1:0]   out_idx_q;
	logic [PW-1:0]                 out_prob_q;
	logic [wis_pkg::COUNT_W-1:0]   out_cnt_q;

	logic                          s_fire;
	logic                          is_full;
	logic                          walk_last;
	logic                          out_free;
	logic [wis_pkg::WEIGHT_W-1:0]  s_weight;
	logic [wis_pkg::FRAC_W-1:0]    s_frac;
	logic [PW-1:0]                 quo_next;
	logic [CNT_XW-1:0]             cnt_x;
	logic [IDX_XW-1:0]             pick_x;

	logic                          ram_we;
	logic [AW-1:0]                 ram_raddr;
	logic [wis_pkg::WEIGHT_W-1:0]  ram_rdata;

	wis_pkg::alu_req_t             alu_req;
	wis_pkg::alu_rsp_t             alu_rsp;

	assign s_weight  = s_tdata[wis_pkg::WEIGHT_W-1:0];
	assign s_frac    = s_tdata[wis_pkg::WEIGHT_W +: wis_pkg::FRAC_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign is_full   = (count_q == CNT_W'(ENTRIES));
	assign walk_last = (proc_q == count_q - CNT_W'(1));
	assign out_free  = !m_tvalid_q || m_tready;
	assign quo_next  = {quo_q[PW-2:0], alu_rsp.cout};

	assign ram_we    = s_fire && (s_tuser == wis_pkg::KIND_APPEND) && !is_full;
	assign ram_raddr = (state_q == ST_WALK) ? proc_q[AW-1:0] + AW'(1) : '0;

	wis_ram #(
		.WIDTH(wis_pkg::WEIGHT_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(s_weight),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		alu_req     = '0;
		alu_req.lim = acc_q[wis_pkg::PROD_W-1:wis_pkg::WEIGHT_W];
		case (state_q)
			ST_IDLE: begin
				alu_req.a = wis_pkg::PROD_W'(total_q);
				alu_req.b = wis_pkg::PROD_W'(s_weight);
			end
			ST_MUL: begin
				alu_req.a = {acc_q[wis_pkg::PROD_W-2:0], 1'b0};
				alu_req.b = frac_q[wis_pkg::FRAC_W-1] ? wis_pkg::PROD_W'(total_q) : '0;
			end
			ST_WALK: begin
				alu_req.a = wis_pkg::PROD_W'(sum_q);
				alu_req.b = wis_pkg::PROD_W'(ram_rdata);
			end
			ST_SAT: begin
				alu_req.a   = wis_pkg::PROD_W'(w_q);
				alu_req.b   = wis_pkg::PROD_W'(total_q);
				alu_req.sub = 1'b1;
			end
			ST_DIV: begin
				alu_req.a   = wis_pkg::PROD_W'({rem_q, 1'b0});
				alu_req.b   = wis_pkg::PROD_W'(total_q);
				alu_req.sub = 1'b1;
			end
			default: begin
				alu_req.sub = 1'b0;
			end
		endcase
	end

	wis_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	// sequencer and stored state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (s_tuser == wis_pkg::KIND_APPEND) begin
							if (!is_full) begin
								count_q <= count_q + CNT_W'(1);
								total_q <= alu_rsp.res[TW-1:0];
							end
							state_q <= ST_FIN;
						end else if (count_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (step_q == MUL_LAST) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (alu_rsp.gt || walk_last) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					if (total_q == '0 || alu_rsp.cout) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == DIV_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					found_q <= 1'b0;
					pick_q  <= '0;
					quo_q   <= '0;
					full_q  <= (s_tuser == wis_pkg::KIND_APPEND) && is_full;
					acc_q   <= '0;
					frac_q  <= s_frac;
					sum_q   <= '0;
					proc_q  <= '0;
					step_q  <= '0;
				end
			end
			ST_MUL: begin
				acc_q  <= alu_rsp.res;
				frac_q <= {frac_q[wis_pkg::FRAC_W-2:0], 1'b0};
				step_q <= step_q + SW'(1);
			end
			ST_WALK: begin
				sum_q   <= alu_rsp.res[TW-1:0];
				w_q     <= ram_rdata;
				pick_q  <= proc_q[AW-1:0];
				found_q <= 1'b1;
				proc_q  <= proc_q + CNT_W'(1);
			end
			ST_SAT: begin
				rem_q  <= TW'(w_q);
				step_q <= '0;
				if (total_q == '0) begin
					quo_q <= '0;
				end else if (alu_rsp.cout) begin
					quo_q <= '1;
				end else begin
					quo_q <= '0;
				end
			end
			ST_DIV: begin
				quo_q  <= quo_next;
				step_q <= step_q + SW'(1);
				if (alu_rsp.cout) begin
					rem_q <= alu_rsp.res[TW-1:0];
				end else begin
					rem_q <= {rem_q[TW-2:0], 1'b0};
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_found_q <= found_q;
					out_full_q  <= full_q;
					out_idx_q   <= pick_x[wis_pkg::INDEX_W-1:0];
					out_prob_q  <= quo_q;
					out_cnt_q   <= cnt_x[wis_pkg::COUNT_W-1:0];
				end
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

	assign cnt_x  = CNT_XW'(count_q);
	assign pick_x = IDX_XW'(pick_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = wis_pkg::M_TDATA_W'({out_cnt_q, out_prob_q, out_idx_q});
	assign m_tuser  = {out_full_q, out_found_q};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("stored count above table depth");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> proc_q < count_q)
		else $error("walk past stored entries");

	a_sample_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_tuser == wis_pkg::KIND_SAMPLE && count_q != '0 |=> state_q == ST_MUL)
		else $error("sample request did not start multiply");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside finish state");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_tuser == wis_pkg::KIND_APPEND && is_full |=>
		$stable(count_q) && $stable(total_q))
		else $error("rejected append changed table state");

endmodule
